// ===== rtl/rbte_pkg.sv =====
package rbte_pkg;

  typedef enum logic [1:0] {
    MODE_B16 = 2'd0,
    MODE_B24 = 2'd1,
    MODE_B32 = 2'd2,
    MODE_B64 = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_B64;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Alphabets: character 0 sits in the top byte of each constant
  localparam logic [16*8-1:0] ALPHA16 = "0123456789ABCDEF";
  localparam logic [24*8-1:0] ALPHA24 = "BCDFGHJKMPQRTVWXY2346789";
  localparam logic [32*8-1:0] ALPHA32 = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  localparam logic [64*8-1:0] ALPHA64 =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One request after classification: up to three looked-up characters,
  // then a run of padding.
  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       two;
    logic       flush;
    logic [2:0] pad;
    logic       eod;
  } entry_t;

  function automatic logic [3:0] digit_width(mode_t mode);
    case (mode)
      MODE_B16: return 4'd4;
      MODE_B24: return 4'd4;
      MODE_B32: return 4'd5;
      MODE_B64: return 4'd6;
      default:  return 4'd6;
    endcase
  endfunction

  function automatic logic [2:0] block_bytes(mode_t mode);
    case (mode)
      MODE_B32: return 3'd5;
      MODE_B64: return 3'd3;
      default:  return 3'd1;
    endcase
  endfunction

  // Padding after the flushed digit, by bytes held in the partial block
  function automatic logic [2:0] pad_count(mode_t mode, logic [2:0] bytes);
    case (mode)
      MODE_B32: begin
        case (bytes)
          3'd1:    return 3'd6;
          3'd2:    return 3'd4;
          3'd3:    return 3'd3;
          3'd4:    return 3'd1;
          default: return 3'd0;
        endcase
      end
      MODE_B64: begin
        case (bytes)
          3'd1:    return 3'd2;
          3'd2:    return 3'd1;
          default: return 3'd0;
        endcase
      end
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lookup_char(mode_t mode, logic [5:0] d);
    case (mode)
      MODE_B16: return ALPHA16[8*(15 - int'(d[3:0])) +: 8];
      MODE_B24: begin
        if (d < 6'd24) begin
          return ALPHA24[8*(23 - int'(d)) +: 8];
        end else begin
          return ALPHA24[8*23 +: 8];
        end
      end
      MODE_B32: return ALPHA32[8*(31 - int'(d[4:0])) +: 8];
      MODE_B64: return ALPHA64[8*(63 - int'(d)) +: 8];
      default:  return ALPHA64[8*(63 - int'(d)) +: 8];
    endcase
  endfunction

endpackage

// ===== rtl/rbte_front.sv =====
module rbte_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             q_full,
  output logic             q_push,
  output rbte_pkg::entry_t q_entry
);
  import rbte_pkg::*;

  mode_t      mode_r;
  logic [5:0] pend_r;
  logic [3:0] bpos_r;
  logic [2:0] bib_r;

  logic [3:0] w, need, r, r2, rem;
  logic [5:0] mask;
  logic [7:0] sh0, sh1, low_bits;
  logic [5:0] d0, d1raw, d1;
  logic       two;
  logic [5:0] pend_nxt;
  logic [3:0] bpos_nxt;
  logic [2:0] bib_inc, bib_nxt;
  logic       flush;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    w    = digit_width(mode_r);
    need = (bpos_r == 4'd0 || bpos_r > w) ? w : bpos_r;
    r    = 4'd8 - need;
    mask = 6'((7'd1 << w) - 7'd1);
    sh0  = in_tdata >> r;
    d0   = (pend_r | sh0[5:0]) & mask;

    two   = (r >= w);
    r2    = r - w;
    sh1   = in_tdata >> r2;
    d1raw = sh1[5:0] & mask;
    // base24 maps the low nibble from the far end of the alphabet
    d1    = (mode_r == MODE_B24) ? 6'(6'd23 - d1raw) : d1raw;

    rem      = two ? r2 : r;
    low_bits = in_tdata & 8'((9'd1 << rem) - 9'd1);
    pend_nxt = (rem == 4'd0) ? 6'd0 : 6'(low_bits << (w - rem));
    bpos_nxt = w - rem;

    bib_inc = bib_r + 3'd1;
    bib_nxt = (bib_inc >= block_bytes(mode_r)) ? 3'd0 : bib_inc;
    flush   = in_tlast && (bib_nxt != 3'd0);

    q_entry.ch0   = lookup_char(mode_r, d0);
    q_entry.ch1   = lookup_char(mode_r, d1);
    q_entry.ch2   = lookup_char(mode_r, pend_nxt & mask);
    q_entry.two   = two;
    q_entry.flush = flush;
    q_entry.pad   = flush ? pad_count(mode_r, bib_nxt) : 3'd0;
    q_entry.eod   = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      pend_r <= '0;
      bpos_r <= digit_width(MODE_RESET);
      bib_r  <= '0;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_wdata);
      pend_r <= '0;
      bpos_r <= digit_width(mode_t'(cfg_wdata));
      bib_r  <= '0;
    end else if (q_push) begin
      if (in_tlast) begin
        pend_r <= '0;
        bpos_r <= w;
        bib_r  <= '0;
      end else begin
        pend_r <= pend_nxt;
        bpos_r <= bpos_nxt;
        bib_r  <= bib_nxt;
      end
    end
  end

  a_bib_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    bib_r < block_bytes(mode_r))
    else $error("byte count left its block");

  a_eod_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_tlast && !cfg_wr_en) |=>
      (bib_r == 3'd0 && pend_r == 6'd0 && bpos_r == digit_width(mode_r)))
    else $error("stream state not cleared after end of message");

endmodule

// ===== rtl/rbte_fifo.sv =====
module rbte_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rbte_pkg::entry_t wr_entry,
  input  logic             pop,
  output rbte_pkg::entry_t rd_entry,
  output logic             empty,
  output logic             full
);
  import rbte_pkg::*;

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 do_push, do_pop;

  assign empty    = (count_r == Q_CNT_W'(0));
  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign rd_entry = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count over depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

endmodule

// ===== rtl/rbte_back.sv =====
module rbte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rbte_pkg::entry_t q_entry,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);
  import rbte_pkg::*;

  logic [2:0] k_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic [3:0] last_idx;
  logic       at_end;
  logic       load;
  logic [7:0] char_nxt;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    last_idx = 4'(q_entry.two) + 4'(q_entry.flush) + 4'(q_entry.pad);
    at_end   = ({1'b0, k_r} == last_idx);
    load     = !q_empty && (!out_valid_r || out_tready);
    q_pop    = load && at_end;
    // byte digits, then the flushed digit, then padding
    if (k_r == 3'd0) begin
      char_nxt = q_entry.ch0;
    end else if (k_r == 3'd1 && q_entry.two) begin
      char_nxt = q_entry.ch1;
    end else if (q_entry.flush && {1'b0, k_r} == 4'd1 + 4'(q_entry.two)) begin
      char_nxt = q_entry.ch2;
    end else begin
      char_nxt = PAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      k_r         <= at_end ? 3'd0 : k_r + 3'd1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= char_nxt;
      out_last_r <= q_entry.eod && at_end;
    end
  end

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (k_r == 3'd0))
    else $error("character index moved without a queued request");

endmodule

// ===== rtl/radix_bitpack_text_encoder.sv =====
// Channel  | Ports      | tdata / tlast / tuser
// ---------+------------+------------------------------------------
// in       | in_t*      | data_byte[7:0] / end_of_data / -
// out      | out_t*     | out_char[7:0]  / last_char   / -
// cfg      | cfg_wr_en  | cfg_wdata[1:0] = mode
//
// Each request yields 1 to 8 characters, one per cycle while out_tready
// is high, out of the output register: two for base16/base24, one or two
// for base32/base64, plus the flushed digit and padding at end of data.
// The front classifies a request in the cycle it is accepted and parks it
// in a 4-entry queue; input flows on while output stalls until it is full.
// Reset (rst_n low, synchronous) sets mode to base64 and clears the stream.
module radix_bitpack_text_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wdata,   // mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // data_byte[7:0]
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_char[7:0]
  output logic       out_tlast
);
  import rbte_pkg::*;

  entry_t push_entry, head_entry;
  logic   push, pop, q_empty, q_full;

  rbte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  rbte_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (head_entry),
    .empty    (q_empty),
    .full     (q_full)
  );

  rbte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_entry    (head_entry),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
